// ----- hdl/trsc_pkg.sv -----
// ----------------------------------------------------------------------------
// Tiny register/stack CPU core package
// Item types, operation codes and opcodes shared by the core and its users.
// ----------------------------------------------------------------------------
package trsc_pkg;

  localparam int DATA_MEM_DEPTH_DEF = 256;
  localparam int DATA_WIDTH_DEF     = 32;
  localparam int PC_W               = 11;
  localparam logic [7:0] SP_RESET   = 8'h10;

  // Operation carried by an input item.
  typedef enum logic [1:0] {
    OP_EXEC  = 2'd0,
    OP_WRITE = 2'd1,
    OP_READ  = 2'd2
  } operation_t;

  // Instruction opcodes (upper nibble of the instruction byte).
  typedef enum logic [3:0] {
    OPC_STORE = 4'h0,
    OPC_RET   = 4'h1,
    OPC_MOVI  = 4'h2,
    OPC_LDIND = 4'h3,
    OPC_LOAD  = 4'h4,
    OPC_HALT  = 4'h5,
    OPC_DJNZ  = 4'h8,
    OPC_SUB   = 4'h9,
    OPC_JNZ   = 4'hA,
    OPC_ADD   = 4'hB,
    OPC_LCALL = 4'hC,
    OPC_POP   = 4'hD,
    OPC_JMP   = 4'hE,
    OPC_PUSH  = 4'hF
  } opcode_t;

  typedef struct packed {
    logic [1:0]  operation;
    logic [7:0]  instr_byte;
    logic [7:0]  operand_byte;
    logic [7:0]  mem_address;
    logic [31:0] mem_data;
  } in_item_t;

  typedef struct packed {
    logic [PC_W-1:0] next_pc;
    logic            halted;
    logic [31:0]     read_data;
  } out_item_t;

endpackage

// ----- hdl/tiny_register_stack_cpu_core_top.sv -----
// After acceptance an item passes through the first work state, the second for lcall and
// ret, and the finish state; its result is registered when the finish state commits.
// The data memory has a single port, one access per cycle; lcall and ret need two accesses.
// The input side takes the next item in the cycle the current one completes.
// Reset (rst_n, synchronous, active low): PC 0, SP 16, registers 0, halt flag clear;
// data memory contents are undefined until written.
// ----------------------------------------------------------------------------
// Tiny register/stack CPU core
// Executes one instruction per item against a register file and a data memory
// held in synchronous RAMs; also serves direct data memory writes and reads.
// ----------------------------------------------------------------------------
module tiny_register_stack_cpu_core_top
  import trsc_pkg::*;
#(
  parameter int DATA_MEM_DEPTH = DATA_MEM_DEPTH_DEF,
  parameter int DATA_WIDTH     = DATA_WIDTH_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  in_item_t  in_item,
  output logic      out_valid,
  input  logic      out_ready,
  output out_item_t out_item
);

  localparam int AW = $clog2(DATA_MEM_DEPTH);
  localparam int MW = (DATA_WIDTH > 32) ? DATA_WIDTH : 32;

  typedef enum logic [3:0] {
    ST_IDLE   = 4'b0001,
    ST_FIRST  = 4'b0010,
    ST_SECOND = 4'b0100,
    ST_FINISH = 4'b1000
  } st_t;

  // Memory index: address modulo the depth by restoring subtraction (quotient < 16).
  function automatic logic [AW-1:0] mem_index(input logic [7:0] addr);
    logic [11:0] rem;
    rem = {4'd0, addr};
    for (int k = 3; k >= 0; k--) begin
      if (rem >= (12'(DATA_MEM_DEPTH) << k)) begin
        rem = rem - (12'(DATA_MEM_DEPTH) << k);
      end
    end
    return rem[AW-1:0];
  endfunction

  st_t                   state_r, state_nxt;
  in_item_t              item_r;
  logic [PC_W-1:0]       pc_r, pc_nxt;
  logic [7:0]            sp_r, sp_nxt;
  logic                  halt_r, halt_nxt;
  logic [DATA_WIDTH-1:0] rf_r [4];
  logic [DATA_WIDTH-1:0] rf_a_r, rf_b_r;
  logic [DATA_WIDTH-1:0] dmem [DATA_MEM_DEPTH];
  logic [DATA_WIDTH-1:0] rdata_r;
  logic [2:0]            ret_hi_r;
  logic                  out_valid_r;
  out_item_t             out_item_r, out_item_nxt;

  logic                  in_acc, out_free, commit;
  logic                  is_exec, need_second;
  opcode_t               opc;
  logic [1:0]            rn, ra, rb;
  logic [7:0]            ob;
  logic [PC_W-1:0]       pc_inc, pc_rel;
  logic [7:0]            sp_m1, sp_m2, sp_p1, sp_p2;
  logic [DATA_WIDTH-1:0] rf_dec;
  logic                  mem_en, mem_we;
  logic [7:0]            mem_addr;
  logic [DATA_WIDTH-1:0] mem_wd;
  logic [AW-1:0]         mem_idx;
  logic                  rf_we;
  logic [DATA_WIDTH-1:0] rf_wd;
  logic                  rf_we_c;
  logic [MW-1:0]         rdata_ext;

  // Handshake
  assign out_free  = !out_valid_r || out_ready;
  assign commit    = (state_r == ST_FINISH) && out_free;
  assign in_ready  = (state_r == ST_IDLE) || commit;
  assign in_acc    = in_valid && in_ready;
  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

  // Decode of the item at work
  assign opc     = opcode_t'(item_r.instr_byte[7:4]);
  assign rn      = item_r.instr_byte[1:0];
  assign ob      = item_r.operand_byte;
  assign is_exec = (item_r.operation == OP_EXEC) && !halt_r;
  assign need_second = is_exec && ((opc == OPC_LCALL) || (opc == OPC_RET));

  assign pc_inc = pc_r + PC_W'(1) + PC_W'(!item_r.instr_byte[4]);
  assign pc_rel = pc_inc + {{(PC_W-8){ob[7]}}, ob};
  assign sp_m1  = sp_r - 8'd1;
  assign sp_m2  = sp_r - 8'd2;
  assign sp_p1  = sp_r + 8'd1;
  assign sp_p2  = sp_r + 8'd2;
  assign rf_dec = rf_a_r - DATA_WIDTH'(1);

  assign ra = in_item.instr_byte[1:0];
  assign rb = in_item.instr_byte[3:2];

  // Data memory access: one per cycle, in the first and second work cycles.
  always_comb begin
    mem_en   = 1'b0;
    mem_we   = 1'b0;
    mem_addr = 8'd0;
    mem_wd   = '0;
    if (state_r == ST_FIRST) begin
      if (item_r.operation == OP_WRITE) begin
        mem_en   = 1'b1;
        mem_we   = 1'b1;
        mem_addr = item_r.mem_address;
        mem_wd   = DATA_WIDTH'(item_r.mem_data);
      end else if (item_r.operation == OP_READ) begin
        mem_en   = 1'b1;
        mem_addr = item_r.mem_address;
      end else if (is_exec) begin
        unique case (opc) inside
          OPC_STORE: begin
            mem_en   = 1'b1;
            mem_we   = 1'b1;
            mem_addr = ob;
            mem_wd   = rf_a_r;
          end
          OPC_LOAD: begin
            mem_en   = 1'b1;
            mem_addr = ob;
          end
          OPC_LDIND: begin
            mem_en   = 1'b1;
            mem_addr = rf_b_r[7:0];
          end
          OPC_PUSH: begin
            mem_en   = 1'b1;
            mem_we   = 1'b1;
            mem_addr = sp_r;
            mem_wd   = rf_a_r;
          end
          OPC_POP, OPC_RET: begin
            mem_en   = 1'b1;
            mem_addr = sp_m1;
          end
          OPC_LCALL: begin
            mem_en   = 1'b1;
            mem_we   = 1'b1;
            mem_addr = sp_r;
            mem_wd   = DATA_WIDTH'(pc_inc[7:0]);
          end
          default: begin
          end
        endcase
      end
    end else if (state_r == ST_SECOND) begin
      mem_en = 1'b1;
      if (opc == OPC_LCALL) begin
        mem_we   = 1'b1;
        mem_addr = sp_p1;
        mem_wd   = DATA_WIDTH'(pc_inc[PC_W-1:8]);
      end else begin
        mem_addr = sp_m2;
      end
    end
  end

  assign mem_idx = mem_index(mem_addr);

  always_ff @(posedge clk) begin
    if (mem_en) begin
      if (mem_we) begin
        dmem[mem_idx] <= mem_wd;
      end else begin
        rdata_r <= dmem[mem_idx];
      end
    end
  end

  // Architectural update when the item completes.
  always_comb begin
    pc_nxt   = pc_r;
    sp_nxt   = sp_r;
    halt_nxt = halt_r;
    rf_we    = 1'b0;
    rf_wd    = rdata_r;
    if (is_exec) begin
      pc_nxt = pc_inc;
      unique case (opc) inside
        OPC_LOAD, OPC_LDIND: begin
          rf_we = 1'b1;
        end
        OPC_POP: begin
          rf_we  = 1'b1;
          sp_nxt = sp_m1;
        end
        OPC_MOVI: begin
          rf_we = 1'b1;
          rf_wd = DATA_WIDTH'(ob);
        end
        OPC_ADD: begin
          rf_we = 1'b1;
          rf_wd = rf_a_r + DATA_WIDTH'(rf_b_r[7:0]);
        end
        OPC_SUB: begin
          rf_we = 1'b1;
          rf_wd = rf_a_r - DATA_WIDTH'(rf_b_r[7:0]);
        end
        OPC_JNZ: begin
          if (rf_a_r[7:0] != 8'd0) begin
            pc_nxt = pc_rel;
          end
        end
        OPC_DJNZ: begin
          rf_we = 1'b1;
          rf_wd = rf_dec;
          if (rf_dec[7:0] != 8'd0) begin
            pc_nxt = pc_rel;
          end
        end
        OPC_JMP: begin
          pc_nxt = pc_rel;
        end
        OPC_LCALL: begin
          sp_nxt = sp_p2;
          pc_nxt = {item_r.instr_byte[PC_W-9:0], ob};
        end
        OPC_RET: begin
          sp_nxt = sp_m2;
          pc_nxt = {ret_hi_r, 8'd0} | rdata_r[PC_W-1:0];
        end
        OPC_PUSH: begin
          sp_nxt = sp_p1;
        end
        OPC_HALT: begin
          halt_nxt = 1'b1;
        end
        default: begin
        end
      endcase
    end
  end

  assign rf_we_c   = commit && rf_we;
  assign rdata_ext = MW'(rdata_r);

  always_comb begin
    out_item_nxt.next_pc   = pc_nxt;
    out_item_nxt.halted    = halt_nxt;
    out_item_nxt.read_data = (item_r.operation == OP_READ) ? rdata_ext[31:0] : 32'd0;
  end

  // Sequencer
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          state_nxt = ST_FIRST;
        end
      end
      ST_FIRST: begin
        state_nxt = need_second ? ST_SECOND : ST_FINISH;
      end
      ST_SECOND: begin
        state_nxt = ST_FINISH;
      end
      ST_FINISH: begin
        if (commit) begin
          state_nxt = in_acc ? ST_FIRST : ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      pc_r        <= '0;
      sp_r        <= SP_RESET;
      halt_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (commit) begin
        pc_r        <= pc_nxt;
        sp_r        <= sp_nxt;
        halt_r      <= halt_nxt;
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      item_r <= in_item;
    end
    if (commit) begin
      out_item_r <= out_item_nxt;
    end
    // High byte of the return address, read first by ret.
    if (state_r == ST_SECOND) begin
      ret_hi_r <= rdata_r[2:0];
    end
  end

  // Register file: written at completion, read when an item is accepted.
  // A write in the same cycle is forwarded to the read.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < 4; i++) begin
        rf_r[i] <= '0;
      end
    end else if (rf_we_c) begin
      rf_r[rn] <= rf_wd;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      rf_a_r <= (rf_we_c && (rn == ra)) ? rf_wd : rf_r[ra];
      rf_b_r <= (rf_we_c && (rn == rb)) ? rf_wd : rf_r[rb];
    end
  end

`ifndef NO_ASSERTIONS
  a_accept_starts: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> state_r == ST_FIRST)
    else $error("accepted item did not start work");

  a_second_access: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_FIRST) && need_second |=> state_r == ST_SECOND)
    else $error("lcall or ret skipped its second memory access");

  a_halt_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    halt_r |=> halt_r)
    else $error("halt flag cleared without reset");

  a_mem_in_work: assert property (@(posedge clk) disable iff (!rst_n)
    mem_en |-> (state_r == ST_FIRST) || (state_r == ST_SECOND))
    else $error("data memory accessed outside the work cycles");

  a_commit_outputs: assert property (@(posedge clk) disable iff (!rst_n)
    commit |=> out_valid_r)
    else $error("completed item produced no result");
`endif

endmodule

// ----- test/tiny_register_stack_cpu_core_top_tb.sv -----
// ----------------------------------------------------------------------------
// Tiny register/stack CPU core testbench
// Streams instructions and direct memory accesses into the core and checks
// the PC, the halt flag and the read word of every result. The testbench
// keeps its own copy of the registers, stack and data memory. Items run as
// directed checks, as random programs under several idling mixes, and last as a halt check.
// ----------------------------------------------------------------------------
module tiny_register_stack_cpu_core_top_tb;
  import trsc_pkg::*;

  localparam int STALL_LIMIT = 5000;
  localparam logic [1:0] OP_UNDEFINED = 2'd3;
  localparam logic [3:0] OPC_SPARE6 = 4'h6;
  localparam logic [3:0] OPC_SPARE7 = 4'h7;

  logic      clk;
  logic      rst_n;
  logic      in_valid;
  logic      in_ready;
  in_item_t  in_item;
  logic      out_valid;
  logic      out_ready;
  out_item_t out_item;

  tiny_register_stack_cpu_core_top uut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_item  (in_item),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_item (out_item)
  );

  // Predicted architectural state of the core.
  logic [10:0] core_pc;
  logic [7:0]  core_sp;
  logic [31:0] core_regs [4];
  logic        core_halted;
  logic [31:0] data_mem [256];
  bit          mem_written [256];

  out_item_t expected_results[$];
  int mismatch_count = 0;
  int items_sent = 0;
  int quiet_cycles = 0;
  int sender_idle_pct = 0;
  int receiver_stall_pct = 0;

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  function automatic void store_word(logic [7:0] addr, logic [31:0] data);
    data_mem[addr] = data;
    mem_written[addr] = 1'b1;
  endfunction

  // Applies one item to the predicted state and returns the result it causes.
  function automatic out_item_t predict_core_step(in_item_t it);
    out_item_t   res;
    logic [3:0]  opc;
    logic [1:0]  rn;
    logic [1:0]  rm;
    logic [7:0]  k;
    logic [10:0] pc;
    logic [10:0] offset;
    logic [7:0]  sp;
    logic [7:0]  hi_byte;
    logic [31:0] lo_word;
    res = '0;
    case (it.operation)
      OP_EXEC: begin
        if (!core_halted) begin
          opc = it.instr_byte[7:4];
          rm = it.instr_byte[3:2];
          rn = it.instr_byte[1:0];
          k = it.operand_byte;
          offset = {{3{k[7]}}, k};
          // Two-byte instructions have bit 4 of the opcode byte clear.
          pc = core_pc + (it.instr_byte[4] ? 11'd1 : 11'd2);
          sp = core_sp;
          case (opc)
            OPC_STORE: store_word(k, core_regs[rn]);
            OPC_LOAD:  core_regs[rn] = data_mem[k];
            OPC_MOVI:  core_regs[rn] = {24'd0, k};
            OPC_LDIND: core_regs[rn] = data_mem[core_regs[rm][7:0]];
            OPC_ADD:   core_regs[rn] = core_regs[rn] + {24'd0, core_regs[rm][7:0]};
            OPC_SUB:   core_regs[rn] = core_regs[rn] - {24'd0, core_regs[rm][7:0]};
            OPC_JNZ: begin
              if (core_regs[rn][7:0] != 8'd0) pc = pc + offset;
            end
            OPC_DJNZ: begin
              core_regs[rn] = core_regs[rn] - 32'd1;
              if (core_regs[rn][7:0] != 8'd0) pc = pc + offset;
            end
            OPC_JMP: pc = pc + offset;
            OPC_PUSH: begin
              store_word(sp, core_regs[rn]);
              sp = sp + 8'd1;
            end
            OPC_POP: begin
              sp = sp - 8'd1;
              core_regs[rn] = data_mem[sp];
            end
            OPC_LCALL: begin
              store_word(sp, {24'd0, pc[7:0]});
              store_word(sp + 8'd1, {29'd0, pc[10:8]});
              sp = sp + 8'd2;
              pc = {it.instr_byte[2:0], k};
            end
            OPC_RET: begin
              sp = sp - 8'd1;
              hi_byte = data_mem[sp][7:0];
              sp = sp - 8'd1;
              lo_word = data_mem[sp];
              // The whole low word is ORed in, so its bits 10..8 count too.
              pc = lo_word[10:0] | {hi_byte[2:0], 8'h00};
            end
            OPC_HALT: core_halted = 1'b1;
            default: ;
          endcase
          core_pc = pc;
          core_sp = sp;
        end
      end
      OP_WRITE: store_word(it.mem_address, it.mem_data);
      OP_READ:  res.read_data = data_mem[it.mem_address];
      default: ;
    endcase
    res.next_pc = core_pc;
    res.halted = core_halted;
    return res;
  endfunction

  function automatic logic [7:0] instr(logic [3:0] opc, logic [1:0] rm, logic [1:0] rn);
    return {opc, rm, rn};
  endfunction

  function automatic logic [31:0] random_word();
    case ($urandom_range(0, 5))
      0: return 32'h0000_0000;
      1: return 32'hFFFF_FFFF;
      2: return 32'h8000_0000;
      default: return $urandom;
    endcase
  endfunction

  function automatic in_item_t exec_item(logic [7:0] ib, logic [7:0] k);
    in_item_t it;
    it.operation = OP_EXEC;
    it.instr_byte = ib;
    it.operand_byte = k;
    it.mem_address = 8'($urandom);
    it.mem_data = $urandom;
    return it;
  endfunction

  function automatic in_item_t mem_item(logic [1:0] op, logic [7:0] addr, logic [31:0] data);
    in_item_t it;
    it.operation = op;
    it.instr_byte = 8'($urandom);
    it.operand_byte = 8'($urandom);
    it.mem_address = addr;
    it.mem_data = data;
    return it;
  endfunction

  // Any opcode but halt, which would freeze the core for the rest of the run.
  function automatic in_item_t random_exec_item();
    logic [3:0] opc;
    do opc = 4'($urandom_range(0, 15)); while (opc == OPC_HALT);
    return exec_item({opc, 4'($urandom)}, 8'($urandom));
  endfunction

  function automatic in_item_t random_mem_item();
    int pick;
    pick = $urandom_range(0, 9);
    if (pick < 5) return mem_item(OP_WRITE, 8'($urandom), random_word());
    if (pick < 9) return mem_item(OP_READ, 8'($urandom), 32'($urandom));
    return mem_item(OP_UNDEFINED, 8'($urandom), 32'($urandom));
  endfunction

  // Called at a falling edge; returns at the falling edge after acceptance
  // with valid still high, so the next item can follow without a gap.
  task automatic send_item(in_item_t it);
    while ($urandom_range(0, 99) < sender_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_item <= it;
    do @(posedge clk); while (!in_ready);
    expected_results.push_back(predict_core_step(it));
    items_sent++;
    @(negedge clk);
  endtask

  // Data memory is undefined until written, so every word the item is going
  // to read gets a direct write first if it has never been written.
  task automatic send_safe(in_item_t it);
    logic [7:0] reads[$];
    if (it.operation == OP_READ) begin
      reads.push_back(it.mem_address);
    end else if (it.operation == OP_EXEC && !core_halted) begin
      case (it.instr_byte[7:4])
        OPC_LOAD:  reads.push_back(it.operand_byte);
        OPC_LDIND: reads.push_back(core_regs[it.instr_byte[3:2]][7:0]);
        OPC_POP:   reads.push_back(core_sp - 8'd1);
        OPC_RET: begin
          reads.push_back(core_sp - 8'd1);
          reads.push_back(core_sp - 8'd2);
        end
        default: ;
      endcase
    end
    foreach (reads[i])
      if (!mem_written[reads[i]]) send_item(mem_item(OP_WRITE, reads[i], random_word()));
    send_item(it);
  endtask

  task automatic test_direct_memory();
    send_safe(mem_item(OP_WRITE, 8'h00, 32'h0000_0000));
    send_safe(mem_item(OP_WRITE, 8'hFF, 32'hFFFF_FFFF));
    send_safe(mem_item(OP_WRITE, 8'h01, 32'h8000_0000));
    send_safe(mem_item(OP_READ, 8'hFF, 32'h1234_5678));
    send_safe(mem_item(OP_READ, 8'h00, 32'hFFFF_FFFF));
    send_safe(mem_item(OP_UNDEFINED, 8'h01, 32'hDEAD_BEEF));
  endtask

  task automatic test_instruction_set();
    send_safe(exec_item(instr(OPC_MOVI, 2'd0, 2'd0), 8'hFF));
    send_safe(exec_item(instr(OPC_MOVI, 2'd0, 2'd1), 8'h80));
    send_safe(exec_item(instr(OPC_ADD, 2'd0, 2'd2), 8'h00));
    // Subtracting into a zero register wraps below zero.
    send_safe(exec_item(instr(OPC_SUB, 2'd0, 2'd3), 8'h00));
    send_safe(exec_item(instr(OPC_SUB, 2'd1, 2'd2), 8'h00));
    send_safe(exec_item(instr(OPC_STORE, 2'd0, 2'd3), 8'h40));
    send_safe(exec_item(instr(OPC_LOAD, 2'd0, 2'd0), 8'h40));
    send_safe(exec_item(instr(OPC_LDIND, 2'd0, 2'd1), 8'h00));
    send_safe(exec_item(instr(OPC_PUSH, 2'd0, 2'd3), 8'h00));
    send_safe(exec_item(instr(OPC_POP, 2'd0, 2'd2), 8'h00));
    send_safe(exec_item(instr(OPC_JNZ, 2'd0, 2'd0), 8'hFE));
    send_safe(exec_item(instr(OPC_MOVI, 2'd0, 2'd1), 8'h00));
    send_safe(exec_item(instr(OPC_JNZ, 2'd0, 2'd1), 8'h7F));
    send_safe(exec_item(instr(OPC_DJNZ, 2'd0, 2'd1), 8'h80));
    send_safe(exec_item(instr(OPC_MOVI, 2'd0, 2'd2), 8'h01));
    send_safe(exec_item(instr(OPC_DJNZ, 2'd0, 2'd2), 8'h10));
    send_safe(exec_item(instr(OPC_JMP, 2'd0, 2'd0), 8'h7F));
    // Call to the top of the program space; the next item wraps the PC to 0.
    send_safe(exec_item(instr(OPC_LCALL, 2'd1, 2'd3), 8'hFF));
    send_safe(exec_item(instr(OPC_SPARE7, 2'd0, 2'd0), 8'h00));
    send_safe(exec_item(instr(OPC_RET, 2'd0, 2'd0), 8'h00));
    send_safe(exec_item(instr(OPC_SPARE6, 2'd3, 2'd3), 8'hAA));
  endtask

  // Short programs: stack pairs, calls with returns, counted loops and
  // store/load-back chains, mixed with loose instructions and memory traffic.
  task automatic run_random_block();
    int kind;
    int count;
    logic [1:0] ra;
    logic [1:0] rb;
    logic [7:0] addr;
    kind = $urandom_range(0, 8);
    ra = 2'($urandom);
    rb = 2'($urandom);
    addr = 8'($urandom);
    case (kind)
      0, 1, 2: send_safe(random_exec_item());
      3: send_safe(random_mem_item());
      4: begin
        send_safe(exec_item(instr(OPC_PUSH, 2'($urandom), ra), 8'($urandom)));
        repeat ($urandom_range(0, 2)) send_safe(random_exec_item());
        send_safe(exec_item(instr(OPC_POP, 2'($urandom), rb), 8'($urandom)));
      end
      5: begin
        send_safe(exec_item(instr(OPC_LCALL, 2'($urandom), 2'($urandom)), 8'($urandom)));
        repeat ($urandom_range(0, 3)) send_safe(random_exec_item());
        send_safe(exec_item(instr(OPC_RET, 2'($urandom), 2'($urandom)), 8'($urandom)));
      end
      6: begin
        count = $urandom_range(1, 6);
        send_safe(exec_item(instr(OPC_MOVI, 2'($urandom), ra), 8'(count)));
        repeat (count)
          send_safe(exec_item(instr(OPC_DJNZ, 2'($urandom), ra), {1'b1, 7'($urandom)}));
      end
      7: begin
        send_safe(exec_item(instr(OPC_MOVI, 2'($urandom), rb), addr));
        send_safe(exec_item(instr(OPC_STORE, 2'($urandom), ra), addr));
        send_safe(exec_item(instr(OPC_LDIND, rb, 2'($urandom)), 8'($urandom)));
      end
      default: begin
        send_safe(mem_item(OP_WRITE, addr, random_word()));
        send_safe(mem_item(OP_READ, addr, 32'($urandom)));
      end
    endcase
  endtask

  task automatic test_random_programs();
    int idle_mix[4];
    int stall_mix[4];
    int stop_at[4];
    idle_mix = '{0, 64, 0, 27};
    stall_mix = '{0, 0, 64, 27};
    stop_at = '{400, 750, 1100, 1420};
    foreach (stop_at[i]) begin
      sender_idle_pct = idle_mix[i];
      receiver_stall_pct = stall_mix[i];
      while (items_sent < stop_at[i]) run_random_block();
    end
  endtask

  // Once halted, instructions are dropped but direct memory access still works.
  task automatic test_halt();
    send_safe(exec_item(instr(OPC_HALT, 2'd2, 2'd3), 8'h5A));
    send_safe(exec_item(instr(OPC_MOVI, 2'd0, 2'd0), 8'h77));
    send_safe(exec_item(instr(OPC_LCALL, 2'd1, 2'd1), 8'h23));
    send_safe(exec_item(instr(OPC_RET, 2'd0, 2'd0), 8'h00));
    send_safe(mem_item(OP_WRITE, 8'h33, 32'hCAFE_F00D));
    send_safe(mem_item(OP_READ, 8'h33, 32'h0));
    send_safe(mem_item(OP_UNDEFINED, 8'h33, 32'hFFFF_FFFF));
  endtask

  always @(negedge clk) begin
    out_ready <= ($urandom_range(0, 99) >= receiver_stall_pct);
  end

  always @(posedge clk) begin
    out_item_t want;
    if (rst_n && out_valid && out_ready) begin
      if (expected_results.size() == 0) begin
        $error("result with no item pending: next_pc %0h", out_item.next_pc);
        mismatch_count++;
      end else begin
        want = expected_results.pop_front();
        if (out_item.next_pc !== want.next_pc) begin
          $error("next_pc: expected %0h, got %0h", want.next_pc, out_item.next_pc);
          mismatch_count++;
        end
        if (out_item.halted !== want.halted) begin
          $error("halted: expected %0b, got %0b", want.halted, out_item.halted);
          mismatch_count++;
        end
        if (out_item.read_data !== want.read_data) begin
          $error("read_data: expected %0h, got %0h", want.read_data, out_item.read_data);
          mismatch_count++;
        end
      end
    end
  end

  // Ends the run when neither side has moved an item for too long.
  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_item = '0;
    out_ready = 1'b0;
    core_pc = '0;
    core_sp = SP_RESET;
    core_halted = 1'b0;
    foreach (core_regs[i]) core_regs[i] = '0;
    foreach (data_mem[i]) begin
      data_mem[i] = '0;
      mem_written[i] = 1'b0;
    end
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    test_direct_memory();
    test_instruction_set();
    test_random_programs();
    test_halt();

    in_valid <= 1'b0;
    while (expected_results.size() != 0) @(negedge clk);
    repeat (10) @(negedge clk);
    if (mismatch_count == 0 && expected_results.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
hdl/trsc_pkg.sv
hdl/tiny_register_stack_cpu_core_top.sv
test/tiny_register_stack_cpu_core_top_tb.sv
